### sv/uci_pkg.sv
`timescale 1ns / 1ps
package uci_pkg;

  // Table and fixed-point geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int NCNT_W        = ADDR_W + 1;
  localparam int T_W           = FRACTION_BITS + 1;   // t in [0, 1.0]
  localparam int COEF_W        = 40;
  localparam int ENTRY_W       = 4 * COEF_W;
  localparam int DIFF_W        = 33;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int NUMINT_W      = 11;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ARG       = 2'd0,
    CFG_STEP_INV      = 2'd1,
    CFG_NUM_INTERVALS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                operation;
    logic [9:0]         interval_index;
    logic signed [31:0] sample_at_start;
    logic signed [31:0] sample_at_third;
    logic signed [31:0] sample_at_two_thirds;
    logic signed [31:0] sample_at_end;
    logic signed [31:0] arg_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] approx_value;
    logic               out_of_range;
  } out_word_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c0;
  } coef_entry_t;

  // Scaled argument handed from the scaler to the evaluator
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [T_W-1:0]    t;
    logic              flag;
  } scale_t;

endpackage

### sv/uniform_cubic_table_interpolator.sv
`timescale 1ns / 1ps
// Evaluate words pass stages 1-7 (stage 4 reads the table) and the output register.
// One load or evaluate word per cycle when not stalled; a load yields no result word.
// Loads follow evaluates through stages 1-3 and write the table where evaluates read it.
// Stalls on the result side back up stage by stage; empty stages still take words.
// Reset (rst_n low, synchronous) empties the pipeline and sets min_arg 0,
// step_inv 1.0, num_intervals 1024; the coefficient table is not cleared.
module uniform_cubic_table_interpolator import uci_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Coefficients of the cubic through the four samples at t = 0, 1/3, 2/3, 1.
  // Constant multiplies reduce to shift-add; halving is an arithmetic shift.
  function automatic coef_entry_t coef_calc(
    input logic signed [31:0] y0,
    input logic signed [31:0] y1,
    input logic signed [31:0] y2,
    input logic signed [31:0] y3
  );
    logic signed [COEF_W-1:0] a, b, c, d;
    coef_entry_t e;
    a    = COEF_W'(y0);
    b    = COEF_W'(y1);
    c    = COEF_W'(y2);
    d    = COEF_W'(y3);
    e.c0 = a;
    e.c1 = (-11 * a + 18 * b - 9 * c + 2 * d) >>> 1;
    e.c2 = (18 * a - 45 * b + 36 * c - 9 * d) >>> 1;
    e.c3 = (-9 * a + 27 * b - 27 * c + 9 * d) >>> 1;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers (must be written only while idle; the block does not check)
  // ---------------------------------------------------------------------------
  logic signed [31:0]    min_arg_r;
  logic [31:0]           step_inv_r;
  logic [NUMINT_W-1:0]   num_intervals_r;
  logic [NCNT_W-1:0]     n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_arg_r       <= '0;
      step_inv_r      <= 32'h0001_0000;
      num_intervals_r <= NUMINT_W'(TABLE_ENTRIES);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_ARG:       min_arg_r       <= cfg_wdata;
        CFG_STEP_INV:      step_inv_r      <= cfg_wdata;
        CFG_NUM_INTERVALS: num_intervals_r <= cfg_wdata[NUMINT_W-1:0];
        default: ;
      endcase
    end
  end

  // Intervals in use, forced into 1..TABLE_ENTRIES
  always_comb begin
    if (num_intervals_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (32'(num_intervals_r) > 32'(TABLE_ENTRIES)) begin
      n_eff = NCNT_W'(TABLE_ENTRIES);
    end else begin
      n_eff = NCNT_W'(num_intervals_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register. Loads carry finished coefficients, evaluates
  // carry x - min_arg; both move on through the scaler in word order.
  // ---------------------------------------------------------------------------
  logic                     s1_v_r, s1_load_r;
  logic [9:0]               s1_idx_r;
  coef_entry_t              s1_coef_r;
  logic signed [DIFF_W-1:0] s1_diff_r;
  logic                     s1_go;
  logic                     sc_in_ready;

  assign s1_go    = !s1_v_r || sc_in_ready;
  assign in_ready = s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_go) begin
      s1_v_r <= in_valid;
    end
    if (s1_go && in_valid) begin
      s1_load_r <= (in_data.operation == OP_LOAD);
      s1_idx_r  <= in_data.interval_index;
      s1_coef_r <= coef_calc(in_data.sample_at_start, in_data.sample_at_third,
                             in_data.sample_at_two_thirds, in_data.sample_at_end);
      s1_diff_r <= DIFF_W'(in_data.arg_value) - DIFF_W'(min_arg_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2-3: argument scaling to index / fraction; loads pass alongside
  // ---------------------------------------------------------------------------
  logic        sc_out_valid, sc_out_ready, hn_in_ready;
  logic        sc_load;
  logic [9:0]  sc_widx;
  coef_entry_t sc_coef;
  scale_t      sc_out;

  uci_arg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (sc_in_ready),
    .in_load   (s1_load_r),
    .in_widx   (s1_idx_r),
    .in_coef   (s1_coef_r),
    .diff      (s1_diff_r),
    .step_inv  (step_inv_r),
    .n_eff     (n_eff),
    .out_valid (sc_out_valid),
    .out_ready (sc_out_ready),
    .out_sc    (sc_out),
    .out_load  (sc_load),
    .out_widx  (sc_widx),
    .out_coef  (sc_coef)
  );

  // A load leaves stage 3 by writing the table, never waiting on the evaluator.
  // Only one word leaves stage 3 per edge, so every evaluate reads the table
  // after all older loads and before all younger ones.
  logic ram_we;
  assign sc_out_ready = sc_load || hn_in_ready;
  assign ram_we       = sc_out_valid && sc_load && (32'(sc_widx) < 32'(TABLE_ENTRIES));

  // ---------------------------------------------------------------------------
  // Coefficient table: one write port (loads), one registered read port that
  // advances together with the evaluator's first stage.
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] ram_rdata;

  uci_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(sc_widx)),
    .wdata (sc_coef),
    .re    (sc_out_valid && !sc_load && hn_in_ready),
    .raddr (sc_out.addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stages 4-7 and output: table read, Horner with one multiply each in 5-7, saturate
  // ---------------------------------------------------------------------------
  uci_horner u_horner (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_out_valid && !sc_load),
    .in_ready  (hn_in_ready),
    .in_sc     (sc_out),
    .entry     (coef_entry_t'(ram_rdata)),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sv/uci_ram.sv
`timescale 1ns / 1ps
module uci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### sv/uci_arg_scale.sv
`timescale 1ns / 1ps
module uci_arg_scale import uci_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_load,
  input  logic [9:0]               in_widx,
  input  coef_entry_t              in_coef,
  input  logic signed [DIFF_W-1:0] diff,
  input  logic [31:0]              step_inv,
  input  logic [NCNT_W-1:0]        n_eff,
  output logic                     out_valid,
  input  logic                     out_ready,
  output scale_t                   out_sc,
  output logic                     out_load,
  output logic [9:0]               out_widx,
  output coef_entry_t              out_coef
);

  logic        v2_r, neg2_r;
  logic [63:0] prod2_r;
  logic        v3_r;
  scale_t      sc3_r, sc_nxt;
  logic        rdy2, rdy3;
  logic [31:0] idx;
  // load words ride along so table writes stay in word order
  logic        ld2_r, ld3_r;
  logic [9:0]  widx2_r, widx3_r;
  coef_entry_t coef2_r, coef3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = rdy2;

  // stage 2: Q16.16 offset times Q16.16 reciprocal -> Q32.32
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= in_valid;
    end
    if (rdy2 && in_valid) begin
      neg2_r  <= diff[DIFF_W-1];
      prod2_r <= diff[31:0] * step_inv;
      ld2_r   <= in_load;
      widx2_r <= in_widx;
      coef2_r <= in_coef;
    end
  end

  // stage 3: split into index and fraction, clamp at both ends
  assign idx = prod2_r[63:32];

  always_comb begin
    sc_nxt.addr = idx[ADDR_W-1:0];
    sc_nxt.t    = {1'b0, prod2_r[31 -: FRACTION_BITS]};
    sc_nxt.flag = 1'b0;
    if (neg2_r) begin
      sc_nxt.addr = '0;
      sc_nxt.t    = '0;
      sc_nxt.flag = 1'b1;
    end else if (idx >= 32'(n_eff)) begin
      sc_nxt.addr = ADDR_W'(n_eff - NCNT_W'(1));
      sc_nxt.t    = T_ONE;
      sc_nxt.flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (rdy3 && v2_r) begin
      sc3_r   <= sc_nxt;
      ld3_r   <= ld2_r;
      widx3_r <= widx2_r;
      coef3_r <= coef2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_sc    = sc3_r;
  assign out_load  = ld3_r;
  assign out_widx  = widx3_r;
  assign out_coef  = coef3_r;

endmodule

### sv/uci_horner.sv
`timescale 1ns / 1ps
module uci_horner import uci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  scale_t      in_sc,
  input  coef_entry_t entry,       // table read data, registered at accept
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  localparam int HPROD_W = COEF_W + T_W + 1;
  localparam logic signed [COEF_W-1:0] SAT_HI = {{(COEF_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [COEF_W-1:0] SAT_LO = {{(COEF_W-31){1'b1}}, {31{1'b0}}};

  // c + floor(acc * t / 2^F)
  function automatic logic signed [COEF_W-1:0] horner_step(
    input logic signed [COEF_W-1:0] c,
    input logic signed [COEF_W-1:0] acc,
    input logic [T_W-1:0]           t
  );
    logic signed [HPROD_W-1:0] p;
    p = acc * $signed({1'b0, t});
    return c + COEF_W'(p >>> FRACTION_BITS);
  endfunction

  logic                     v4_r, v5_r, v6_r, v7_r, vo_r;
  logic                     rdy4, rdy5, rdy6, rdy7, rdyo;
  logic [T_W-1:0]           t4_r, t5_r, t6_r;
  logic                     f4_r, f5_r, f6_r, f7_r;
  logic signed [COEF_W-1:0] acc5_r, acc6_r, acc7_r;
  logic signed [COEF_W-1:0] c1_5_r, c0_5_r, c0_6_r;
  logic signed [31:0]       sat_nxt;
  out_word_t                out_r;

  assign rdyo     = !vo_r || out_ready;
  assign rdy7     = !v7_r || rdyo;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
      if (rdyo) vo_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      t4_r <= in_sc.t;
      f4_r <= in_sc.flag;
    end
    if (rdy5 && v4_r) begin
      acc5_r <= horner_step(entry.c2, entry.c3, t4_r);
      c1_5_r <= entry.c1;
      c0_5_r <= entry.c0;
      t5_r   <= t4_r;
      f5_r   <= f4_r;
    end
    if (rdy6 && v5_r) begin
      acc6_r <= horner_step(c1_5_r, acc5_r, t5_r);
      c0_6_r <= c0_5_r;
      t6_r   <= t5_r;
      f6_r   <= f5_r;
    end
    if (rdy7 && v6_r) begin
      acc7_r <= horner_step(c0_6_r, acc6_r, t6_r);
      f7_r   <= f6_r;
    end
    if (rdyo && v7_r) begin
      out_r.approx_value <= sat_nxt;
      out_r.out_of_range <= f7_r;
    end
  end

  always_comb begin
    if (acc7_r > SAT_HI) begin
      sat_nxt = SAT_HI[31:0];
    end else if (acc7_r < SAT_LO) begin
      sat_nxt = SAT_LO[31:0];
    end else begin
      sat_nxt = acc7_r[31:0];
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule

### sv/uci_checker.sv
`timescale 1ns / 1ps
module uci_checker import uci_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  localparam int PIPE_SLOTS = 8;

  // evaluate words accepted but not yet delivered
  logic [3:0] pending_r;
  logic       eval_in, word_out;

  assign eval_in  = in_valid && in_ready && (in_data.operation == OP_EVAL);
  assign word_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (eval_in && !word_out) begin
      pending_r <= pending_r + 4'd1;
    end else if (!eval_in && word_out) begin
      pending_r <= pending_r - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result word without an outstanding evaluate");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 4'd0 |-> in_ready)
    else $error("input stalled with no evaluate in flight");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'(PIPE_SLOTS))
    else $error("more evaluates in flight than pipeline slots");

endmodule

bind uniform_cubic_table_interpolator uci_checker u_uci_checker (.*);
